### hdl/ulm_pkg.sv
// ulm_pkg: types, register codes and constants of the ultrasonic level monitor.
// No dependencies; imported by every module of the block.
package ulm_pkg;

	localparam int CAPTURE_BITS_DEF = 32;
	localparam int CAP_W            = 32;
	localparam int TIME_W           = 63;
	localparam int SUM_W            = 40;
	localparam int CNT_W            = 16;
	localparam int PROD_W           = 48;	// largest product: 100*tick_sum + base*T < 2^48
	localparam int MULR_W           = 16;
	localparam int REG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 63;

	localparam int SOUND_US_PER_CM  = 58;
	localparam int PERCENT_SCALE    = 100;

	localparam logic [7:0]        TPU_RST     = 8'd80;
	localparam logic [15:0]       MAXP_RST    = 16'd35000;
	localparam logic [9:0]        HEIGHT_RST  = 10'd89;
	localparam logic [6:0]        THRESH_RST  = 7'd25;
	localparam logic [15:0]       BLOCK_RST   = 16'd3600;
	localparam logic [TIME_W-1:0] HOLDOFF_RST = 63'd86400000000;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_TICKS_PER_US  = 3'd0,
		REG_MAX_PULSE_US  = 3'd1,
		REG_BARREL_HEIGHT = 3'd2,
		REG_THRESHOLD     = 3'd3,
		REG_BLOCK_SAMPLES = 3'd4,
		REG_HOLDOFF_US    = 3'd5
	} ulm_reg_t;

	typedef struct packed {
		logic [7:0]        ticks_per_us;
		logic [15:0]       max_pulse_us;
		logic [9:0]        height_cm;
		logic [6:0]        thresh_pct;
		logic [15:0]       block_samples;
		logic [TIME_W-1:0] holdoff_us;
	} ulm_cfg_t;

	typedef struct packed {
		logic              command;
		logic [CAP_W-1:0]  capture_count;
		logic [TIME_W-1:0] now_us;
	} ulm_in_t;

	typedef struct packed {
		logic             measured;
		logic [CAP_W-1:0] pulse_ticks;
		logic             in_range;
		logic             block_done;
		logic             below_threshold;
		logic             send_alert;
	} ulm_out_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] mcand;
		logic [MULR_W-1:0] mplr;
		logic [PROD_W-1:0] addend;
	} ulm_mul_req_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LIM  = 4'b0010,
		S_MUL  = 4'b0100,
		S_OUT  = 4'b1000
	} ulm_state_t;

	// multiply sequence for the block-end compare
	typedef enum logic [2:0] {
		STP_TH   = 3'd0,	// tpu * H
		STP_THN  = 3'd1,	// * n
		STP_BASE = 3'd2,	// * 58
		STP_LHS  = 3'd3,	// base * 100
		STP_SUM  = 3'd4,	// tick_sum * 100
		STP_RHS  = 3'd5		// base * T + tick_sum * 100
	} ulm_step_t;

endpackage

### hdl/ulm_cfg_regs.sv
// ulm_cfg_regs: configuration register file of the level monitor.
// Depends on ulm_pkg for the register codes and the config struct.
module ulm_cfg_regs
	import ulm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output ulm_cfg_t              cfg
);

	ulm_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_us  <= TPU_RST;
			cfg_q.max_pulse_us  <= MAXP_RST;
			cfg_q.height_cm     <= HEIGHT_RST;
			cfg_q.thresh_pct    <= THRESH_RST;
			cfg_q.block_samples <= BLOCK_RST;
			cfg_q.holdoff_us    <= HOLDOFF_RST;
		end else if (wr_en) begin
			case (ulm_reg_t'(wr_index))
				REG_TICKS_PER_US:  cfg_q.ticks_per_us  <= wr_data[7:0];
				REG_MAX_PULSE_US:  cfg_q.max_pulse_us  <= wr_data[15:0];
				REG_BARREL_HEIGHT: cfg_q.height_cm     <= wr_data[9:0];
				REG_THRESHOLD:     cfg_q.thresh_pct    <= wr_data[6:0];
				REG_BLOCK_SAMPLES: cfg_q.block_samples <= wr_data[15:0];
				REG_HOLDOFF_US:    cfg_q.holdoff_us    <= wr_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hdl/ulm_ser_mul.sv
// ulm_ser_mul: bit-serial shift-add multiplier, one multiplier bit per cycle.
// Result = mcand * mplr + addend; stops as soon as no multiplier bits remain.
// Depends on ulm_pkg.
module ulm_ser_mul
	import ulm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ulm_mul_req_t      req,
	output logic              done,
	output logic [PROD_W-1:0] prod
);

	logic              busy_q;
	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] mcand_q;
	logic [MULR_W-1:0] mplr_q;

	assign done = busy_q && (mplr_q == '0);
	assign prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// products never reach PROD_W bits, so dropping high multiplicand bits is safe
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q   <= req.addend;
			mcand_q <= req.mcand;
			mplr_q  <= req.mplr;
		end else if (busy_q && !done) begin
			if (mplr_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q <= {mcand_q[PROD_W-2:0], 1'b0};
			mplr_q  <= {1'b0, mplr_q[MULR_W-1:1]};
		end
	end

endmodule

### hdl/ultrasonic_level_threshold_monitor.sv
// Ultrasonic level threshold monitor. Each input beat is one echo-pin edge capture
// with a timestamp; each accepted beat yields exactly one output beat. A falling
// edge runs the pulse-limit multiply (max_pulse_us * ticks_per_us), one multiplier
// bit per cycle through the shared serial multiplier. A falling edge that completes
// a block adds six more serial multiplies for the exact mean-fill compare. A
// finished result sits in an output register, so the next beat is taken while it
// waits. Config writes are accepted in every cycle.
// Depends on ulm_pkg, ulm_cfg_regs and ulm_ser_mul.
module ultrasonic_level_threshold_monitor
	import ulm_pkg::*;
#(
	parameter int CAPTURE_BITS = CAPTURE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ulm_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ulm_out_t              out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ulm_cfg_t     cfg;
	ulm_mul_req_t mreq;
	logic         mul_done;
	logic [PROD_W-1:0] mul_prod;

	ulm_state_t state_q;
	ulm_step_t  step_q;

	logic [CAPTURE_BITS-1:0] start_q;
	logic [CNT_W-1:0]        sample_cnt_q;
	logic [SUM_W-1:0]        sum_q;
	logic [TIME_W-1:0]       last_alert_q;
	logic                    ever_q;
	logic                    out_valid_q;

	logic [CAPTURE_BITS-1:0] width_q;
	logic [TIME_W-1:0]       now_q;
	logic [CNT_W-1:0]        n_q;
	logic [PROD_W-1:0]       base_q;
	logic [PROD_W-1:0]       lhs_q;
	logic                    hold_ok_q;
	ulm_out_t                res_q;
	ulm_out_t                out_q;

	logic             in_acc;
	logic             lim_done;
	logic             pulse_ok;
	logic [CNT_W-1:0] n_next;
	logic             blk_end;
	logic             rhs_done;
	logic             below;
	logic             send;
	logic             out_load;

	assign cfg_ready = 1'b1;

	ulm_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	ulm_ser_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign lim_done = (state_q == S_LIM) && mul_done;
	assign pulse_ok = PROD_W'(width_q) <= mul_prod;
	assign n_next   = sample_cnt_q + 1'b1;
	assign blk_end  = n_next >= cfg.block_samples;
	assign rhs_done = (state_q == S_MUL) && mul_done && (step_q == STP_RHS);
	assign below    = lhs_q < mul_prod;
	assign send     = below && hold_ok_q;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// operand select for the shared multiplier; the TH, THN and BASE steps multiply the last product, SUM adds it
	always_comb begin
		mreq = '0;
		if (in_acc && !in_data.command) begin
			mreq.start = 1'b1;
			mreq.mcand = PROD_W'(cfg.max_pulse_us);
			mreq.mplr  = MULR_W'(cfg.ticks_per_us);
		end else if (lim_done && pulse_ok && blk_end) begin
			mreq.start = 1'b1;
			mreq.mcand = PROD_W'(cfg.height_cm);
			mreq.mplr  = MULR_W'(cfg.ticks_per_us);
		end else if ((state_q == S_MUL) && mul_done) begin
			case (step_q)
				STP_TH: begin
					mreq.start = 1'b1;
					mreq.mcand = mul_prod;
					mreq.mplr  = n_q;
				end
				STP_THN: begin
					mreq.start = 1'b1;
					mreq.mcand = mul_prod;
					mreq.mplr  = MULR_W'(SOUND_US_PER_CM);
				end
				STP_BASE: begin
					mreq.start = 1'b1;
					mreq.mcand = mul_prod;
					mreq.mplr  = MULR_W'(PERCENT_SCALE);
				end
				STP_LHS: begin
					mreq.start = 1'b1;
					mreq.mcand = PROD_W'(sum_q);
					mreq.mplr  = MULR_W'(PERCENT_SCALE);
				end
				STP_SUM: begin
					mreq.start  = 1'b1;
					mreq.mcand  = base_q;
					mreq.mplr   = MULR_W'(cfg.thresh_pct);
					mreq.addend = mul_prod;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			step_q       <= STP_TH;
			start_q      <= '0;
			sample_cnt_q <= '0;
			sum_q        <= '0;
			last_alert_q <= '0;
			ever_q       <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_data.command) begin
							start_q <= in_data.capture_count[CAPTURE_BITS-1:0];
							state_q <= S_OUT;
						end else begin
							state_q <= S_LIM;
						end
					end
				end
				S_LIM: begin
					if (mul_done) begin
						if (!pulse_ok) begin
							state_q <= S_OUT;
						end else begin
							sum_q <= sum_q + SUM_W'(width_q);
							if (blk_end) begin
								step_q  <= STP_TH;
								state_q <= S_MUL;
							end else begin
								sample_cnt_q <= n_next;
								state_q      <= S_OUT;
							end
						end
					end
				end
				S_MUL: begin
					if (mul_done) begin
						case (step_q)
							STP_TH:   step_q <= STP_THN;
							STP_THN:  step_q <= STP_BASE;
							STP_BASE: step_q <= STP_LHS;
							STP_LHS:  step_q <= STP_SUM;
							STP_SUM:  step_q <= STP_RHS;
							default: begin
								if (send) begin
									last_alert_q <= now_q;
									ever_q       <= 1'b1;
								end
								sample_cnt_q <= '0;
								sum_q        <= '0;
								state_q      <= S_OUT;
							end
						endcase
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			width_q <= in_data.capture_count[CAPTURE_BITS-1:0] - start_q;
			now_q   <= in_data.now_us;
			res_q   <= '0;
		end
		if (lim_done) begin
			res_q.measured    <= 1'b1;
			res_q.pulse_ticks <= CAP_W'(width_q);
			res_q.in_range    <= pulse_ok;
			res_q.block_done  <= pulse_ok && blk_end;
			n_q               <= n_next;
			hold_ok_q         <= !ever_q ||
				((now_q >= last_alert_q) && ((now_q - last_alert_q) >= cfg.holdoff_us));
		end
		if ((state_q == S_MUL) && mul_done && (step_q == STP_BASE)) begin
			base_q <= mul_prod;
		end
		if ((state_q == S_MUL) && mul_done && (step_q == STP_LHS)) begin
			lhs_q <= mul_prod;
		end
		if (rhs_done) begin
			res_q.below_threshold <= below;
			res_q.send_alert      <= send;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// one beat in flight: no second accept right after the first
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while an item is in flight");

	a_flag_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((!out_data.send_alert || out_data.below_threshold) &&
			(!out_data.below_threshold || out_data.block_done) &&
			(!out_data.block_done || out_data.in_range) &&
			(!out_data.in_range || out_data.measured)))
		else $error("inconsistent result flags");

	a_unmeasured_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.measured) |-> (out_data.pulse_ticks == '0))
		else $error("pulse width on a rising-edge result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sample_cnt_q != '1)
		else $error("sample count overran the block length");

	a_alert_latch: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(ever_q) |-> 1'b0)
		else $error("alert history lost outside reset");

endmodule
